// ===== design/kscd_pkg.sv =====
// kscd_pkg: shared types, codes and scan code tables for the keyboard
// scan code decoder; no dependencies
package kscd_pkg;

    localparam int QUEUE_DEPTH = 32;

    // register addresses
    localparam logic [1:0] REG_LEDS = 2'd0;

    // input command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_HOT  = 2'd2;

    // hotkey event codes
    localparam logic [7:0] EV_UP    = 8'd0;
    localparam logic [7:0] EV_DOWN  = 8'd1;
    localparam logic [7:0] EV_TAB   = 8'd2;
    localparam logic [7:0] EV_SF1   = 8'd3;
    localparam logic [7:0] EV_SF2   = 8'd4;
    localparam logic [7:0] EV_F11   = 8'd5;

    // scan codes and keyboard bytes
    localparam logic [7:0] SC_UP      = 8'h48;
    localparam logic [7:0] SC_DOWN    = 8'h50;
    localparam logic [7:0] SC_TAB     = 8'h0f;
    localparam logic [7:0] SC_LSHIFT  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_LSH_UP  = 8'haa;
    localparam logic [7:0] SC_RSH_UP  = 8'hb6;
    localparam logic [7:0] SC_CAPS    = 8'h3a;
    localparam logic [7:0] SC_NUM     = 8'h45;
    localparam logic [7:0] SC_SCROLL  = 8'h46;
    localparam logic [7:0] SC_F1      = 8'h3b;
    localparam logic [7:0] SC_F2      = 8'h3c;
    localparam logic [7:0] SC_F11     = 8'h57;
    localparam logic [7:0] KB_ACK     = 8'hfa;
    localparam logic [7:0] KB_RESEND  = 8'hfe;
    localparam logic [7:0] LED_CMD    = 8'hed;
    localparam logic [7:0] NO_PENDING = 8'hff;
    localparam logic [7:0] CASE_OFS   = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    localparam logic [7:0] PLAIN_MAP [128] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFT_MAP [128] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
        8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
    };

endpackage

// ===== design/kscd_ram.sv =====
// kscd_ram: generic simple dual port ram with registered read
// no dependencies
module kscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/keyboard_scancode_decoder_unit.sv =====
// keyboard_scancode_decoder_unit: top level of the scan code decoder
// depends on kscd_pkg and kscd_ram
//
// Takes an item while stage one is empty and the output buffer has room (a
// keyboard byte, an idle tick or a start command) and returns up to two result
// items (a character, a hotkey event or a byte to send to the keyboard, then at
// most one queued command byte). Items are spaced by the single write port of
// the command queue ram: a lock key or start writes two bytes, one per cycle.
// A queued byte is read from the ram in the cycle after the item is accepted;
// results pass through the pipeline stages into a four-entry output buffer,
// which lets the next item enter while results still wait to be taken.
module keyboard_scancode_decoder_unit #(
    parameter int QUEUE_DEPTH = kscd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] value
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kscd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    // architectural state
    logic [2:0]    r_init;
    logic [1:0]    r_shift, n_shift;
    logic [2:0]    r_leds, n_leds;
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic          r_ack;
    logic [7:0]    r_pend;

    // pipeline stages
    logic          r_s1_v, r_s1_push2, r_s1_pop, r_s1_hv;
    logic [AW-1:0] r_s1_waddr, r_s1_raddr;
    logic [7:0]    r_s1_wdata;
    t_result       r_s1_h;
    logic          r_s2_v, r_s2_pop, r_s2_hv;
    t_result       r_s2_h;

    // output buffer
    t_result       r_fifo [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_fc;

    logic          accept;
    logic [1:0]    cmd;
    logic [7:0]    kb;
    logic          is_byte, is_start, toggle, do_push, push1, push2, pop;
    logic [7:0]    ch, pend_fwd, rdata;
    logic          hv;
    t_result       h;
    logic [CW-1:0] cnt_mid;
    logic          ack_mid;
    logic [7:0]    pend_mid;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [1:0]    fifo_in_n;
    logic          fifo_out;
    t_result       send_res;

    assign cmd      = s_axis_tuser;
    assign kb       = s_axis_tdata;
    assign is_byte  = (cmd == CMD_BYTE);
    assign is_start = (cmd == CMD_START);

    // room for two results per stage in flight
    assign s_axis_tready = !r_s1_v && ((r_fc + (r_s2_v ? 3'd2 : 3'd0)) <= 3'd2);
    assign accept = s_axis_tvalid && s_axis_tready;

    // pending byte as it will be once the queued read lands
    assign pend_fwd = (r_s2_v && r_s2_pop) ? rdata : r_pend;

    // table lookup with letter case
    always_comb begin
        ch = 8'h00;
        if (!kb[7]) begin
            ch = (r_shift != 2'b00) ? SHIFT_MAP[kb[6:0]] : PLAIN_MAP[kb[6:0]];
        end
        if (ch >= 8'h41 && ch <= 8'h5a && (r_leds[2] == (r_shift != 2'b00))) begin
            ch = ch + CASE_OFS;
        end
    end

    // result of the item itself
    always_comb begin
        hv = 1'b0;
        h  = '{kind: KIND_HOT, value: 8'h00, last: 1'b0};
        if (is_byte) begin
            hv = 1'b1;
            if (kb == SC_UP) begin
                h.value = EV_UP;
            end else if (kb == SC_DOWN) begin
                h.value = EV_DOWN;
            end else if (ch != 8'h00) begin
                h.kind  = KIND_CHAR;
                h.value = ch;
            end else if (kb == SC_TAB) begin
                h.value = EV_TAB;
            end else if (kb == SC_F1 && r_shift != 2'b00) begin
                h.value = EV_SF1;
            end else if (kb == SC_F2 && r_shift != 2'b00) begin
                h.value = EV_SF2;
            end else if (kb == SC_F11) begin
                h.value = EV_F11;
            end else if (kb == KB_RESEND) begin
                h.kind  = KIND_SEND;
                h.value = pend_fwd;
            end else begin
                hv = 1'b0;
            end
        end
    end

    // shift and lock state, queue bookkeeping
    always_comb begin
        n_shift = r_shift;
        n_leds  = r_leds;
        toggle  = 1'b0;
        if (is_byte) begin
            if (kb == SC_LSHIFT) n_shift[0] = 1'b1;
            if (kb == SC_RSHIFT) n_shift[1] = 1'b1;
            if (kb == SC_LSH_UP) n_shift[0] = 1'b0;
            if (kb == SC_RSH_UP) n_shift[1] = 1'b0;
            if (kb == SC_CAPS) begin
                n_leds = r_leds ^ 3'b100;
                toggle = 1'b1;
            end
            if (kb == SC_NUM) begin
                n_leds = r_leds ^ 3'b010;
                toggle = 1'b1;
            end
            if (kb == SC_SCROLL) begin
                n_leds = r_leds ^ 3'b001;
                toggle = 1'b1;
            end
        end else if (is_start) begin
            n_leds = r_init;
        end
        do_push  = is_start || toggle;
        push1    = do_push && (r_count < FULL_CNT);
        push2    = do_push && ((r_count + CW'(push1)) < FULL_CNT);
        cnt_mid  = r_count + CW'(push1) + CW'(push2);
        ack_mid  = (is_byte && kb == KB_ACK) ? 1'b0 : r_ack;
        pend_mid = (is_byte && kb == KB_ACK) ? NO_PENDING : pend_fwd;
        pop      = (cnt_mid != '0) && !ack_mid;
    end

    // queue ram write port: first byte on accept, second in the following cycle
    always_comb begin
        we    = 1'b0;
        waddr = r_tail;
        wdata = LED_CMD;
        if (accept && push1) begin
            we = 1'b1;
        end else if (r_s1_v && r_s1_push2) begin
            we    = 1'b1;
            waddr = r_s1_waddr;
            wdata = r_s1_wdata;
        end
    end

    kscd_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_s1_raddr),
        .o_rdata (rdata)
    );

    // state update and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= 3'd0;
            r_shift <= 2'b00;
            r_leds  <= 3'd0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ack   <= 1'b0;
            r_pend  <= NO_PENDING;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_LEDS) begin
                r_init <= pwdata[2:0];
            end
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            if (accept) begin
                r_shift <= n_shift;
                r_leds  <= n_leds;
                if (push1) r_tail <= push2 ? wrap_inc(wrap_inc(r_tail)) : wrap_inc(r_tail);
                if (pop) r_head <= wrap_inc(r_head);
                r_count <= cnt_mid - CW'(pop);
                r_ack   <= ack_mid || pop;
                r_pend  <= pend_mid;
            end else if (r_s2_v && r_s2_pop) begin
                r_pend <= rdata;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_push2 <= push2;
            r_s1_waddr <= wrap_inc(r_tail);
            r_s1_wdata <= {5'd0, n_leds};
            r_s1_pop   <= pop;
            r_s1_raddr <= r_head;
            r_s1_hv    <= hv;
            r_s1_h     <= '{kind: h.kind, value: h.value, last: !pop};
        end
        r_s2_pop <= r_s1_pop;
        r_s2_hv  <= r_s1_hv;
        r_s2_h   <= r_s1_h;
    end

    // output buffer
    assign send_res  = '{kind: KIND_SEND, value: rdata, last: 1'b1};
    assign fifo_in_n = r_s2_v ? (2'(r_s2_hv) + 2'(r_s2_pop)) : 2'd0;
    assign fifo_out  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 2'd0;
            r_rp <= 2'd0;
            r_fc <= 3'd0;
        end else begin
            r_wp <= r_wp + fifo_in_n;
            r_rp <= r_rp + 2'(fifo_out);
            r_fc <= r_fc + 3'(fifo_in_n) - 3'(fifo_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            if (r_s2_hv) begin
                r_fifo[r_wp] <= r_s2_h;
                if (r_s2_pop) r_fifo[r_wp + 2'd1] <= send_res;
            end else if (r_s2_pop) begin
                r_fifo[r_wp] <= send_res;
            end
        end
    end

    assign m_axis_tvalid = (r_fc != 3'd0);
    assign m_axis_tuser  = r_fifo[r_rp].kind;
    assign m_axis_tdata  = r_fifo[r_rp].value;
    assign m_axis_tlast  = r_fifo[r_rp].last;

    assign prdata = {29'd0, r_init};
    assign pready = 1'b1;
endmodule

// ===== design/kscd_checker.sv =====
// kscd_checker: port-level checks for the scan code decoder, bound to the
// top level; depends on kscd_pkg
module kscd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast,
    input logic [31:0] prdata
);
    import kscd_pkg::*;

    // an item is never taken back to back with another
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on back to back cycles");

    // every result carries one of the three kinds
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_CHAR || m_axis_tuser == KIND_SEND
                           || m_axis_tuser == KIND_HOT))
        else $error("bad result kind");

    // hotkey events carry small codes only
    a_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_HOT) |-> (m_axis_tdata <= EV_F11))
        else $error("bad event code");

    // register read back uses only the led bits
    a_prdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[31:3] == 29'd0)
        else $error("stray read data bits");

    // a held result keeps its last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tlast))
        else $error("last flag changed while stalled");
endmodule

bind keyboard_scancode_decoder_unit kscd_checker u_kscd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .prdata        (prdata)
);
